### hw/rtl/jsu_pkg.sv
// jsu_pkg: shared types, byte codes and helper functions for the json string unescaper
// no dependencies; used by json_string_unescape_utf8, jsu_check_pkg and the testbench

package jsu_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_TEXT    = 4'd1,
		PH_ESC     = 4'd2,
		PH_HEX1    = 4'd3,
		PH_WANT_BS = 4'd4,
		PH_WANT_U  = 4'd5,
		PH_HEX2    = 4'd6
	} phase_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_INSIDE = 2'd0;
	localparam status_t ST_CLOSED = 2'd1;
	localparam status_t ST_ERROR  = 2'd2;
	localparam status_t ST_NONE   = 2'd3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_FF  = 8'h0C;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_CR  = 8'h0D;
	localparam logic [7:0] CC_TAB = 8'h09;

	localparam logic [15:0] SUR_HI_MIN = 16'hD800;
	localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	typedef struct packed {
		logic        ok;
		logic [3:0]  val;
	} hex_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
	} utf8_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t       h;
		logic [7:0] t;
		h = '0;
		t = '0;
		case (b) inside
			[8'h30:8'h39]: begin
				t = b - 8'h30;
				h.ok = 1'b1;
			end
			[8'h61:8'h66]: begin
				t = b - 8'h57;
				h.ok = 1'b1;
			end
			[8'h41:8'h46]: begin
				t = b - 8'h37;
				h.ok = 1'b1;
			end
			default: h.ok = 1'b0;
		endcase
		h.val = t[3:0];
		return h;
	endfunction

	// first byte in bits 7:0, unused upper bytes zero
	function automatic utf8_t utf8_pack(input logic [20:0] cp);
		utf8_t u;
		if (cp < 21'h80) begin
			u.bytes = {24'b0, 1'b0, cp[6:0]};
			u.count = 3'd1;
		end else if (cp < 21'h800) begin
			u.bytes = {16'b0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			u.count = 3'd2;
		end else if (cp < 21'h10000) begin
			u.bytes = {8'b0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			u.count = 3'd3;
		end else begin
			u.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
				5'b11110, cp[20:18]};
			u.count = 3'd4;
		end
		return u;
	endfunction

endpackage

### hw/rtl/jsu_if.sv
// jsu_in_if, jsu_out_if: valid/ready channels for raw input bytes and decoded results
// depends on nothing beyond plain logic types

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_req;

	modport source (output valid, output in_byte, output start_req, input ready);
	modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface jsu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_bytes;
	logic [2:0]  out_count;
	logic [1:0]  status;

	modport source (output valid, output out_bytes, output out_count, output status,
		input ready);
	modport sink   (input valid, input out_bytes, input out_count, input status,
		output ready);
endinterface

### hw/rtl/json_string_unescape_utf8.sv
// json_string_unescape_utf8: decodes a quoted json string byte stream to utf-8 bytes
// depends on jsu_pkg and the channel interfaces in jsu_if.sv
//
// Usage:
//   in_ch carries one raw byte per request, with start_req high on the opening
//   quote of each string. out_ch gives exactly one result per input request:
//   up to four decoded bytes (first byte in bits 7:0), their count and a status
//   (inside, closed, error, no string open). A \u escape or surrogate pair
//   produces its utf-8 bytes on the request that carries the last hex digit.
//   Path: a byte accepted from in_ch is held in the input register, and its
//   result is registered in the output register, from which out_ch takes it.
//   Throughput is one byte per cycle while out_ch does not stall, set by the
//   single decode stage between the input and output registers; the decode
//   state is updated in that same stage, so consecutive bytes never wait on it.
//   When the receiver stalls, the output register holds its result, the input
//   register holds the next byte, and in_ch.ready drops until out_ch moves.
//   Reset empties both registers and leaves the block with no string open.

module json_string_unescape_utf8
	import jsu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	jsu_in_if.sink           in_ch,
	jsu_out_if.source        out_ch
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	phase_t      phase_q,  phase_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] hex_acc_q, hex_acc_d;
	logic [15:0] hi_sur_q,  hi_sur_d;

	logic        out_valid_q;
	logic [31:0] out_bytes_q;
	logic [2:0]  out_count_q;
	status_t     out_status_q;

	logic        adv;
	logic        err;
	hex_t        hex;
	logic [15:0] acc_new;
	logic        last_digit;
	logic        acc_lo_sur;
	logic        acc_hi_sur;
	logic [20:0] cp_sel;
	utf8_t       packed_cp;
	logic [31:0] res_bytes;
	logic [2:0]  res_count;
	status_t     res_status;

	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	assign hex        = hex_decode(byte_s1);
	assign acc_new    = {hex_acc_q[11:0], hex.val};
	assign last_digit = (hex_cnt_q == 2'd3);
	assign acc_lo_sur = (acc_new >= SUR_LO_MIN) && (acc_new <= SUR_LO_MAX);
	assign acc_hi_sur = (acc_new >= SUR_HI_MIN) && (acc_new <= SUR_HI_MAX);
	assign cp_sel     = (phase_q == PH_HEX2) ?
		SUPP_BASE + {1'b0, hi_sur_q[9:0], acc_new[9:0]} : {5'b0, acc_new};
	assign packed_cp  = utf8_pack(cp_sel);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1  <= in_ch.in_byte;
			start_s1 <= in_ch.start_req;
		end
	end

	// error decode
	always_comb begin
		err = 1'b0;
		if (start_s1) begin
			err = (byte_s1 != CH_QUOTE);
		end else begin
			unique case (phase_q)
				PH_TEXT:    err = (byte_s1 == CH_NUL);
				PH_ESC:     err = (byte_s1 == CH_NUL);
				PH_HEX1:    err = !hex.ok || (last_digit && (acc_new == 16'h0 || acc_lo_sur));
				PH_HEX2:    err = !hex.ok || (last_digit && !acc_lo_sur);
				PH_WANT_BS: err = (byte_s1 != CH_BSLASH);
				PH_WANT_U:  err = (byte_s1 != CH_U);
				default:    err = 1'b0;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		hex_cnt_d = hex_cnt_q;
		hex_acc_d = hex_acc_q;
		hi_sur_d  = hi_sur_q;
		if (start_s1) begin
			hex_cnt_d = 2'd0;
			hex_acc_d = 16'h0;
			hi_sur_d  = 16'h0;
			phase_d   = PH_TEXT;
		end else begin
			unique case (phase_q)
				PH_TEXT: begin
					if (byte_s1 == CH_QUOTE) begin
						phase_d = PH_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						phase_d = PH_ESC;
					end
				end
				PH_ESC: begin
					if (byte_s1 == CH_U) begin
						phase_d   = PH_HEX1;
						hex_cnt_d = 2'd0;
						hex_acc_d = 16'h0;
					end else begin
						phase_d = PH_TEXT;
					end
				end
				PH_HEX1, PH_HEX2: begin
					hex_acc_d = acc_new;
					hex_cnt_d = hex_cnt_q + 2'd1;
					if (last_digit) begin
						if (phase_q == PH_HEX1 && acc_hi_sur) begin
							hi_sur_d = acc_new;
							phase_d  = PH_WANT_BS;
						end else begin
							phase_d = PH_TEXT;
						end
					end
				end
				PH_WANT_BS: phase_d = PH_WANT_U;
				PH_WANT_U: begin
					phase_d   = PH_HEX2;
					hex_cnt_d = 2'd0;
					hex_acc_d = 16'h0;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (err) begin
			phase_d   = PH_IDLE;
			hex_cnt_d = 2'd0;
			hex_acc_d = 16'h0;
		end
	end

	// result
	always_comb begin
		res_bytes  = 32'h0;
		res_count  = 3'd0;
		res_status = ST_INSIDE;
		if (!start_s1) begin
			unique case (phase_q)
				PH_TEXT: begin
					if (byte_s1 == CH_QUOTE) begin
						res_status = ST_CLOSED;
					end else if (byte_s1 != CH_BSLASH) begin
						res_bytes = {24'h0, byte_s1};
						res_count = 3'd1;
					end
				end
				PH_ESC: begin
					res_count = 3'd1;
					case (byte_s1)
						CH_B:    res_bytes = {24'h0, CC_BS};
						CH_F:    res_bytes = {24'h0, CC_FF};
						CH_N:    res_bytes = {24'h0, CC_LF};
						CH_R:    res_bytes = {24'h0, CC_CR};
						CH_T:    res_bytes = {24'h0, CC_TAB};
						CH_U:    res_count = 3'd0;
						default: res_bytes = {24'h0, byte_s1};
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (last_digit && !(phase_q == PH_HEX1 && acc_hi_sur)) begin
						res_bytes = packed_cp.bytes;
						res_count = packed_cp.count;
					end
				end
				PH_WANT_BS, PH_WANT_U: res_status = ST_INSIDE;
				default: res_status = ST_NONE;
			endcase
		end
		if (err) begin
			res_bytes  = 32'h0;
			res_count  = 3'd0;
			res_status = ST_ERROR;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hex_cnt_q <= 2'd0;
			hex_acc_q <= 16'h0;
			hi_sur_q  <= 16'h0;
		end else if (adv) begin
			phase_q   <= phase_d;
			hex_cnt_q <= hex_cnt_d;
			hex_acc_q <= hex_acc_d;
			hi_sur_q  <= hi_sur_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_bytes_q  <= res_bytes;
			out_count_q  <= res_count;
			out_status_q <= res_status;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_bytes = out_bytes_q;
	assign out_ch.out_count = out_count_q;
	assign out_ch.status    = out_status_q;

	a_err_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && err |=> phase_q == PH_IDLE)
		else $error("decode state not idle after error");

	a_bytes_only_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_count_q != 3'd0 |-> out_status_q == ST_INSIDE)
		else $error("decoded bytes with non-inside status");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_count_q <= 3'd4)
		else $error("byte count out of range");

	a_hex_cnt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		hex_cnt_q != 2'd0 |-> (phase_q == PH_HEX1 || phase_q == PH_HEX2))
		else $error("hex digit count outside a unicode escape");

endmodule

### sim/jsu_check_pkg.sv
// jsu_check_pkg: scoreboard for the json string unescaper, with its own decoder of each request
// depends on jsu_pkg for the phase, status and byte constants

package jsu_check_pkg;
	import jsu_pkg::*;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
		status_t     status;
	} decoded_t;

	class unescape_scoreboard;
		phase_t      phase;
		logic [1:0]  digits;
		logic [15:0] acc;
		logic [15:0] hi_unit;
		decoded_t    decoded_pending[$];
		int unsigned mismatches;

		function new();
			phase = PH_IDLE;
			digits = '0;
			acc = '0;
			hi_unit = '0;
			mismatches = 0;
		endfunction

		function int pending_count();
			return decoded_pending.size();
		endfunction

		function void to_utf8(input logic [20:0] cp, output logic [31:0] bytes,
			output logic [2:0] count);
			logic [7:0] c0, c1, c2;
			c0 = {2'b10, cp[5:0]};
			c1 = {2'b10, cp[11:6]};
			c2 = {2'b10, cp[17:12]};
			if (cp < 21'h80) begin
				bytes = {25'b0, cp[6:0]};
				count = 3'd1;
			end else if (cp < 21'h800) begin
				bytes = {16'b0, c0, 8'hC0 | {3'b0, cp[10:6]}};
				count = 3'd2;
			end else if (cp < 21'h10000) begin
				bytes = {8'b0, c0, c1, 8'hE0 | {4'b0, cp[15:12]}};
				count = 3'd3;
			end else begin
				bytes = {c0, c1, c2, 8'hF0 | {5'b0, cp[20:18]}};
				count = 3'd4;
			end
		endfunction

		function void note_request(input logic [7:0] b, input logic start);
			decoded_t    r;
			logic        err;
			logic        hex_ok;
			logic [3:0]  nib;
			logic [31:0] enc;
			logic [2:0]  n;
			r = '0;
			r.status = ST_INSIDE;
			err = 1'b0;
			hex_ok = 1'b1;
			nib = '0;
			if (start) begin
				digits = '0;
				acc = '0;
				hi_unit = '0;
				if (b == CH_QUOTE) phase = PH_TEXT;
				else err = 1'b1;
			end else begin
				case (phase)
					PH_TEXT: begin
						if (b == CH_QUOTE) begin
							r.status = ST_CLOSED;
							phase = PH_IDLE;
						end else if (b == CH_NUL) err = 1'b1;
						else if (b == CH_BSLASH) phase = PH_ESC;
						else begin
							r.bytes = {24'b0, b};
							r.count = 3'd1;
						end
					end
					PH_ESC: begin
						phase = PH_TEXT;
						if (b == CH_NUL) err = 1'b1;
						else begin
							r.count = 3'd1;
							case (b)
								CH_B: r.bytes = {24'b0, CC_BS};
								CH_F: r.bytes = {24'b0, CC_FF};
								CH_N: r.bytes = {24'b0, CC_LF};
								CH_R: r.bytes = {24'b0, CC_CR};
								CH_T: r.bytes = {24'b0, CC_TAB};
								CH_U: begin
									r.count = 3'd0;
									phase = PH_HEX1;
									digits = '0;
									acc = '0;
								end
								default: r.bytes = {24'b0, b};
							endcase
						end
					end
					PH_HEX1, PH_HEX2: begin
						if (b >= "0" && b <= "9") nib = 4'(b - 8'h30);
						else if (b >= "a" && b <= "f") nib = 4'(b - 8'h57);
						else if (b >= "A" && b <= "F") nib = 4'(b - 8'h37);
						else hex_ok = 1'b0;
						if (!hex_ok) err = 1'b1;
						else begin
							acc = {acc[11:0], nib};
							if (digits != 2'd3) digits = digits + 2'd1;
							else begin
								digits = '0;
								if (phase == PH_HEX1) begin
									if (acc == 16'h0 || (acc >= SUR_LO_MIN && acc <= SUR_LO_MAX))
										err = 1'b1;
									else if (acc >= SUR_HI_MIN && acc <= SUR_HI_MAX) begin
										hi_unit = acc;
										phase = PH_WANT_BS;
									end else begin
										to_utf8({5'b0, acc}, enc, n);
										r.bytes = enc;
										r.count = n;
										phase = PH_TEXT;
									end
								end else if (acc < SUR_LO_MIN || acc > SUR_LO_MAX) err = 1'b1;
								else begin
									to_utf8(SUPP_BASE + {1'b0, hi_unit[9:0], acc[9:0]}, enc, n);
									r.bytes = enc;
									r.count = n;
									phase = PH_TEXT;
								end
							end
						end
					end
					PH_WANT_BS: begin
						if (b == CH_BSLASH) phase = PH_WANT_U;
						else err = 1'b1;
					end
					PH_WANT_U: begin
						if (b == CH_U) begin
							phase = PH_HEX2;
							digits = '0;
							acc = '0;
						end else err = 1'b1;
					end
					default: begin
						phase = PH_IDLE;
						r.status = ST_NONE;
					end
				endcase
			end
			if (err) begin
				r = '0;
				r.status = ST_ERROR;
				phase = PH_IDLE;
				digits = '0;
				acc = '0;
			end
			decoded_pending = {decoded_pending, r};
		endfunction

		task report(input string what, input logic [31:0] got, input logic [31:0] want);
			mismatches++;
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		endtask

		task check_result(input logic [31:0] bytes, input logic [2:0] count,
			input status_t status);
			decoded_t want;
			if (decoded_pending.size() == 0) begin
				report("result with no request waiting", bytes, 32'h0);
			end else begin
				want = decoded_pending.pop_front();
				if (bytes !== want.bytes) report("out_bytes", bytes, want.bytes);
				if (count !== want.count) report("out_count", {29'b0, count}, {29'b0, want.count});
				if (status !== want.status) report("status", {30'b0, status}, {30'b0, want.status});
			end
		endtask
	endclass

endpackage

### sim/testbench.sv
// testbench: drives quoted json strings, well formed and broken, into json_string_unescape_utf8
// depends on jsu_pkg, jsu_if.sv and the scoreboard in jsu_check_pkg

module testbench;
	import jsu_pkg::*;
	import jsu_check_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_REQUESTS = 450;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_idle_pct = 9;
	int unsigned recv_idle_pct = 82;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          requests_sent = 0;
	int          goal;
	logic [15:0] unit_edges [8] = '{16'h0001, 16'h007F, 16'h0080, 16'h07FF,
		16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

	unescape_scoreboard sb = new();

	jsu_in_if  in_ch();
	jsu_out_if out_ch();

	json_string_unescape_utf8 uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.out_bytes, out_ch.out_count, out_ch.status);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else quiet_cycles <= quiet_cycles + 1;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + {4'b0, nib};
		return {4'b0, nib} + ($urandom_range(1) ? 8'h37 : 8'h57);
	endfunction

	task automatic send_request(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.start_req <= start;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_request(b, start);
		requests_sent++;
	endtask

	task automatic send_unit(input logic [15:0] v);
		for (int i = 3; i >= 0; i--) send_request(hex_char(v[i*4 +: 4]), 1'b0);
	endtask

	task automatic send_escaped_unit(input logic [15:0] v);
		send_request(CH_BSLASH, 1'b0);
		send_request(CH_U, 1'b0);
		send_unit(v);
	endtask

	task automatic send_bad_unit(input logic [15:0] v);
		int         bad_at;
		logic [7:0] junk;
		bad_at = $urandom_range(3);
		do junk = 8'($urandom_range(255));
		while ((junk >= "0" && junk <= "9") || (junk >= "a" && junk <= "f") ||
			(junk >= "A" && junk <= "F"));
		for (int i = 3; i > bad_at; i--) send_request(hex_char(v[i*4 +: 4]), 1'b0);
		send_request(junk, 1'b0);
	endtask

	task automatic wait_for_drain();
		in_ch.valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	task automatic send_string();
		int          kind;
		logic [7:0]  b;
		logic [15:0] v, hi, lo;
		if ($urandom_range(99) < 8) begin
			send_request(8'($urandom_range(255)), $urandom_range(3) == 0);
			return;
		end
		send_request(CH_QUOTE, 1'b1);
		repeat ($urandom_range(6)) begin
			kind = $urandom_range(99);
			hi = ($urandom_range(3) == 0) ? ($urandom_range(1) ? SUR_HI_MAX : SUR_HI_MIN)
				: 16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX));
			lo = ($urandom_range(3) == 0) ? ($urandom_range(1) ? SUR_LO_MAX : SUR_LO_MIN)
				: 16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX));
			if (kind < 38) begin
				do b = 8'($urandom_range(1, 255));
				while (b == CH_QUOTE || b == CH_BSLASH);
				send_request(b, 1'b0);
			end else if (kind < 55) begin
				send_request(CH_BSLASH, 1'b0);
				if ($urandom_range(1)) begin
					case ($urandom_range(4))
						0: b = CH_B;
						1: b = CH_F;
						2: b = CH_N;
						3: b = CH_R;
						default: b = CH_T;
					endcase
				end else begin
					do b = 8'($urandom_range(1, 255));
					while (b == CH_U);
				end
				send_request(b, 1'b0);
			end else if (kind < 72) begin
				case ($urandom_range(4))
					0: v = 16'($urandom_range(1, 16'h7F));
					1: v = 16'($urandom_range(16'h80, 16'h7FF));
					2: v = 16'($urandom_range(16'h800, 16'hD7FF));
					3: v = 16'($urandom_range(16'hE000, 16'hFFFF));
					default: v = unit_edges[$urandom_range(7)];
				endcase
				send_escaped_unit(v);
			end else if (kind < 90) begin
				send_escaped_unit(hi);
				send_escaped_unit(lo);
			end else begin
				// broken sequences, each ends the string
				case (kind)
					90: send_request(CH_NUL, 1'b0);
					91: begin
						send_request(CH_BSLASH, 1'b0);
						send_request(CH_NUL, 1'b0);
					end
					92, 93: begin
						send_request(CH_BSLASH, 1'b0);
						send_request(CH_U, 1'b0);
						send_bad_unit(16'($urandom_range(16'hFFFF)));
					end
					94: send_escaped_unit(16'h0000);
					95: send_escaped_unit(lo);
					96: begin
						send_escaped_unit(hi);
						do b = 8'($urandom_range(255));
						while (b == CH_BSLASH);
						send_request(b, 1'b0);
					end
					97: begin
						send_escaped_unit(hi);
						send_request(CH_BSLASH, 1'b0);
						do b = 8'($urandom_range(255));
						while (b == CH_U);
						send_request(b, 1'b0);
					end
					98: begin
						do v = 16'($urandom_range(16'hFFFF));
						while (v >= SUR_LO_MIN && v <= SUR_LO_MAX);
						send_escaped_unit(hi);
						send_escaped_unit(v);
					end
					default: begin
						send_escaped_unit(hi);
						send_request(CH_BSLASH, 1'b0);
						send_request(CH_U, 1'b0);
						send_bad_unit(lo);
					end
				endcase
				return;
			end
		end
		if ($urandom_range(9) != 0) send_request(CH_QUOTE, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.start_req = 1'b0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no string open, then a start on a byte that is not a quote
		send_request(8'hFF, 1'b0);
		send_request(CH_NUL, 1'b1);
		send_request(CH_QUOTE, 1'b1);
		send_request(8'hFF, 1'b0);
		send_request(8'h01, 1'b0);
		send_request(CH_BSLASH, 1'b0);
		send_request(CH_QUOTE, 1'b0);
		send_request(CH_BSLASH, 1'b0);
		send_request(CH_BSLASH, 1'b0);
		send_escaped_unit(16'h0041);
		send_request(CH_QUOTE, 1'b0);
		// nul right after a backslash, then a bare nul
		send_request(CH_QUOTE, 1'b1);
		send_request(CH_BSLASH, 1'b0);
		send_request(CH_NUL, 1'b0);
		send_request(CH_QUOTE, 1'b1);
		send_request(CH_NUL, 1'b0);
		// bad hex digit, then a restart inside an open string
		send_request(CH_QUOTE, 1'b1);
		send_request(CH_BSLASH, 1'b0);
		send_request(CH_U, 1'b0);
		send_request("G", 1'b0);
		send_request(CH_QUOTE, 1'b1);
		send_request(CH_QUOTE, 1'b1);
		send_request(CH_QUOTE, 1'b0);
		wait_for_drain();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 82;
					hold_left = 300;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			goal = requests_sent + PHASE_REQUESTS;
			while (requests_sent < goal) send_string();
			wait_for_drain();
		end

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_count() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
